// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

    // default list depth
    localparam int DQ_DEPTH = 32;

    // field widths of the streams
    localparam int KEY_W    = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 6;
    localparam int OUT_W    = 48;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 3'd0,
        REQ_DEL_KEY   = 3'd1,
        REQ_DEL_FIRST = 3'd2,
        REQ_DEL_LAST  = 3'd3,
        REQ_DUMP      = 3'd4
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_DEL  = 2'd2,
        S_DUMP = 2'd3
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic match;      // compare all cells to the key
        logic exec;       // carry out a single-result request
        logic del_key;    // remove first match, or flag not found
        logic dump_emit;  // emit one dumped entry
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result
        logic is_del_key;
        logic is_dump;
        logic empty;
        logic dump_last;  // current dump entry is the final one
    } t_dp_sts;

endpackage

// ===== hw/rtl/dq_ctrl.sv =====
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dq_pkg::t_dp_sts i_sts,
    output dq_pkg::t_dp_cmd o_cmd
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (i_sts.is_del_key) begin
                    n_state = S_DEL;
                end else if (i_sts.is_dump && !i_sts.empty) begin
                    n_state = S_DUMP;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_DUMP: begin
                if (i_sts.out_free && i_sts.dump_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs, no request taken while in reset
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            S_RUN: begin
                if (i_sts.is_del_key) begin
                    o_cmd.match = 1'b1;
                end else if (!(i_sts.is_dump && !i_sts.empty)) begin
                    o_cmd.exec = i_sts.out_free;
                end
            end
            S_DEL: begin
                o_cmd.del_key = i_sts.out_free;
            end
            S_DUMP: begin
                o_cmd.dump_emit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/dq_datapath.sv =====
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dq_pkg::t_dp_cmd           i_cmd,
    output dq_pkg::t_dp_sts           o_sts,
    input  logic [dq_pkg::REQ_W-1:0]  i_req,
    input  logic [dq_pkg::KEY_W-1:0]  i_key,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [dq_pkg::OUT_W-1:0]  o_out_data,
    output logic                      o_out_last
);
    import dq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // cell array, front at index zero
    logic signed [KEY_W-1:0] r_entries [DEPTH];
    logic signed [KEY_W-1:0] n_entries [DEPTH];
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;

    // captured request
    t_req                    r_req;
    logic signed [KEY_W-1:0] r_key;
    logic [DEPTH-1:0]        r_match;
    logic [IW-1:0]           r_idx;

    // output register
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic                    r_out_last;

    logic                    full;
    logic                    empty;
    logic                    any_match;
    logic                    dump_last;
    logic                    out_free;
    logic                    emit;
    logic [DEPTH-1:0]        prefix;
    logic [DEPTH-1:0]        shift_mask;
    t_status                 res_status;
    logic signed [KEY_W-1:0] res_value;
    logic [POS_W-1:0]        res_pos;
    logic [CNT_W-1:0]        res_count;
    logic                    res_last;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign any_match = |r_match;
    assign dump_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit      = i_cmd.exec || i_cmd.del_key || i_cmd.dump_emit;

    assign o_sts.out_free   = out_free;
    assign o_sts.is_del_key = (r_req == REQ_DEL_KEY);
    assign o_sts.is_dump    = (r_req == REQ_DUMP);
    assign o_sts.empty      = empty;
    assign o_sts.dump_last  = dump_last;

    // inclusive prefix or: marks the first match and every cell behind it
    always_comb begin
        prefix = r_match;
        for (int s = 1; s < DEPTH; s = s * 2) begin
            prefix = prefix | (prefix << s);
        end
    end

    // next cell contents, count and status for the edit
    always_comb begin
        n_entries  = r_entries;
        n_count    = r_count;
        shift_mask = '0;
        res_status = ST_OK;
        if (i_cmd.exec) begin
            unique case (r_req)
                REQ_INSERT: begin
                    if (full) begin
                        res_status = ST_FULL;
                    end else begin
                        n_entries[0] = r_key;
                        for (int i = 1; i < DEPTH; i++) begin
                            n_entries[i] = r_entries[i-1];
                        end
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_DEL_FIRST: begin
                    if (empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        shift_mask = '1;
                        n_count    = r_count - CW'(1);
                    end
                end
                REQ_DEL_LAST: begin
                    if (empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                REQ_DUMP: res_status = ST_EMPTY;
                default:  res_status = ST_OK;
            endcase
        end
        if (i_cmd.del_key) begin
            if (any_match) begin
                shift_mask = prefix;
                n_count    = r_count - CW'(1);
            end else begin
                res_status = ST_NOT_FOUND;
            end
        end
        // close the gap left by a removed cell
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (shift_mask[i]) n_entries[i] = r_entries[i+1];
        end
    end

    // result fields
    always_comb begin
        if (i_cmd.dump_emit) begin
            res_value = r_entries[r_idx];
            res_pos   = POS_W'(r_idx);
            res_count = CNT_W'(r_count);
            res_last  = dump_last;
        end else begin
            res_value = '0;
            res_pos   = '0;
            res_count = CNT_W'(n_count);
            res_last  = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_req       <= REQ_INSERT;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) r_req <= t_req'(i_req);
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cells, key, match vector and dump index
    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_cmd.load) begin
            r_key <= i_key;
            r_idx <= '0;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (CW'(i) < r_count) && (r_entries[i] == r_key);
            end
        end
        if (i_cmd.dump_emit) r_idx <= r_idx + IW'(1);
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {(OUT_W - CNT_W - POS_W - KEY_W - STATUS_W)'(0),
                           res_count, res_pos, res_value, res_status};
            r_out_last <= res_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending transaction");

    a_del_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.del_key && any_match) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete by key did not drop the count");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_req == REQ_INSERT && !full)
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not raise the count");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.match, i_cmd.exec, i_cmd.del_key, i_cmd.dump_emit}))
        else $error("more than one datapath command at once");

endmodule

// ===== hw/rtl/deque_with_delete_by_key_top.sv =====
// ordered list of up to DEPTH signed 32-bit keys with front insert and
// delete by key, delete first, delete last and dump requests.
// slave stream: s_axis_tuser carries the request code, s_axis_tdata the key.
// master stream: one result per request, or one per entry for a dump,
// m_axis_tlast marks the final result of a request.
// a request is taken in the idle state and worked in the run state: insert,
// delete first, delete last and unused codes finish there, delete by key
// does the parallel compare of all cells there and the shift in the delete
// state, and a dump of a non-empty list moves on to the dump state, where
// the single read port on the cell row emits one entry per cycle while the
// output register is free.
// results go through one output register, so a new request is accepted
// while a result still waits; when the receiver stalls, the block holds its
// next result and stops accepting after the request that needs it.
// reset (synchronous, active low) empties the list and drops any pending
// result; the cell contents are left as they were.
module deque_with_delete_by_key_top #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [dq_pkg::KEY_W-1:0] s_axis_tdata,  // [31:0] key
    input  logic [dq_pkg::REQ_W-1:0] s_axis_tuser,  // [2:0] req_type
    // result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [dq_pkg::OUT_W-1:0] m_axis_tdata,  // [1:0] status, [33:2] entry_value,
                                                    // [38:34] position, [44:39] count
    output logic                     m_axis_tlast
);
    import dq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // cell row and result register
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (s_axis_tuser),
        .i_key       (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ===== verif/deque_with_delete_by_key_top_test.sv =====
`timescale 1ns / 100ps

module deque_with_delete_by_key_top_test;

    import dq_pkg::*;

    // request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI  = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

    localparam int RAND_REQS = 460;

    // one result as the master stream carries it
    typedef struct packed {
        t_status                   status;
        logic signed [KEY_W-1:0]   value;
        logic        [POS_W-1:0]   pos;
        logic        [CNT_W-1:0]   cnt;
        logic                      last;
    } t_list_result;

    // one request waiting to be offered
    typedef struct {
        logic [REQ_W-1:0] code;
        logic [KEY_W-1:0] key;
        int unsigned      gap;
        bit               sync;
    } t_list_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [KEY_W-1:0]   s_axis_tdata = '0;
    logic [REQ_W-1:0]   s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;

    t_list_request      pending_requests[$];
    t_list_result       due_results[$];
    logic [KEY_W-1:0]   shadow_list[$];

    bit                 req_taken = 1'b0;
    bit                 res_taken = 1'b0;
    bit                 tx_burst = 1'b0;
    bit                 rx_burst = 1'b0;
    bit                 rx_hold = 1'b0;
    int unsigned        tx_idle = 0;
    int unsigned        rx_stall = 0;
    int unsigned        reqs_accepted = 0;
    int unsigned        mismatch_count = 0;

    deque_with_delete_by_key_top #(
        .DEPTH(DQ_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [31:0] key
        .s_axis_tuser (s_axis_tuser),   // [2:0] req_type
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // [1:0] status, [33:2] entry_value,
                                        // [38:34] position, [44:39] count
        .m_axis_tlast (m_axis_tlast)
    );

    // clock and reset
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // update the shadow list with one request and queue what it must return
    function automatic void apply_list_request(logic [REQ_W-1:0] code,
                                               logic [KEY_W-1:0] key);
        t_list_result r;
        int           hit;
        r      = '0;
        r.last = 1'b1;
        hit    = -1;
        case (code)
            REQ_INSERT: begin
                if (shadow_list.size() >= DQ_DEPTH) r.status = ST_FULL;
                else shadow_list.push_front(key);
            end
            REQ_DEL_KEY: begin
                foreach (shadow_list[i])
                    if (hit < 0 && shadow_list[i] == key) hit = i;
                if (hit < 0) r.status = ST_NOT_FOUND;
                else shadow_list.delete(hit);
            end
            REQ_DEL_FIRST: begin
                if (shadow_list.size() == 0) r.status = ST_EMPTY;
                else void'(shadow_list.pop_front());
            end
            REQ_DEL_LAST: begin
                if (shadow_list.size() == 0) r.status = ST_EMPTY;
                else void'(shadow_list.pop_back());
            end
            REQ_DUMP: begin
                if (shadow_list.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // one result per entry, front first
                    foreach (shadow_list[i]) begin
                        r.value = shadow_list[i];
                        r.pos   = POS_W'(i);
                        r.cnt   = CNT_W'(shadow_list.size());
                        r.last  = (i == shadow_list.size() - 1);
                        due_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.cnt = CNT_W'(shadow_list.size());
        due_results.push_back(r);
    endfunction

    // compare one result transaction with the oldest one owed
    function automatic void check_result();
        t_list_result got;
        t_list_result want;
        got.status = t_status'(m_axis_tdata[1:0]);
        got.value  = m_axis_tdata[33:2];
        got.pos    = m_axis_tdata[38:34];
        got.cnt    = m_axis_tdata[44:39];
        got.last   = m_axis_tlast;
        if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: status %0d value %0d pos %0d count %0d last %0b",
                         got.status, got.value, got.pos, got.cnt, got.last);
        end else begin
            want = due_results.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"mismatch: expected status %0d value %0d pos %0d count %0d ",
                              "last %0b, got status %0d value %0d pos %0d count %0d last %0b"},
                             want.status, want.value, want.pos, want.cnt, want.last,
                             got.status, got.value, got.pos, got.cnt, got.last);
            end
        end
    endfunction

    // idle cycles before the next result is taken, with stretches of none
    function automatic int unsigned draw_rx_stall();
        if ($urandom_range(39, 0) == 0) rx_burst = !rx_burst;
        return rx_burst ? 0 : $urandom_range(13, 0);
    endfunction

    // key mostly from a small pool so deletes by key often hit
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9, 0))
            6:       return $urandom();
            7:       return KEY_MAX - $urandom_range(3, 0);
            8:       return KEY_MIN + $urandom_range(3, 0);
            9:       return -$urandom_range(3, 1);
            default: return $urandom_range(7, 0);
        endcase
    endfunction

    task automatic queue_request(logic [REQ_W-1:0] code, logic [KEY_W-1:0] key,
                                 bit sync = 1'b0);
        t_list_request item;
        if ($urandom_range(39, 0) == 0) tx_burst = !tx_burst;
        item.code = code;
        item.key  = key;
        item.gap  = tx_burst ? 0 : $urandom_range(13, 0);
        item.sync = sync;
        pending_requests.push_back(item);
    endtask

    // sample both handshakes, predict on each accepted request
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        res_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            apply_list_request(s_axis_tuser, s_axis_tdata);
            reqs_accepted++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
    end

    // request driver
    always @(negedge i_clk) begin : req_drive
        t_list_request nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !req_taken) begin
            // keep offering the same transaction
        end else if (tx_idle != 0) begin
            s_axis_tvalid <= 1'b0;
            tx_idle       <= tx_idle - 1;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].sync && due_results.size() != 0)) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nxt           = pending_requests.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= nxt.code;
            s_axis_tdata  <= nxt.key;
            tx_idle       <= nxt.gap;
        end
    end

    // result acceptor
    always @(negedge i_clk) begin : res_drive
        int unsigned stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end else if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else if (res_taken) begin
            stall         = draw_rx_stall();
            m_axis_tready <= (stall == 0);
            rx_stall      <= (stall == 0) ? 0 : stall - 1;
        end else if (rx_stall != 0) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // long receiver hold so the block backs up and stalls its input
    initial begin
        while (reqs_accepted < 150) @(posedge i_clk);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // stimulus and end of run
    initial begin
        int unsigned cuts[3][5];
        int unsigned mode;
        int unsigned blk_len;
        int unsigned roll;
        int unsigned made;
        logic [REQ_W-1:0] code;

        // thresholds per mode: insert, del key, del first, del last, dump
        cuts[0] = '{70, 78, 84, 90, 96};
        cuts[1] = '{12, 42, 62, 82, 96};
        cuts[2] = '{40, 60, 70, 80, 95};

        // empty list cases
        queue_request(REQ_DUMP, '0);
        queue_request(REQ_DEL_FIRST, '0);
        queue_request(REQ_DEL_LAST, '0);
        queue_request(REQ_DEL_KEY, '0);
        // extremes and duplicates, front ends up as 0 5 5 0 -1 min max
        queue_request(REQ_INSERT, KEY_MAX);
        queue_request(REQ_INSERT, KEY_MIN);
        queue_request(REQ_INSERT, '1);
        queue_request(REQ_INSERT, '0);
        queue_request(REQ_INSERT, 32'd5);
        queue_request(REQ_INSERT, 32'd5);
        queue_request(REQ_INSERT, '0);
        queue_request(REQ_DUMP, '0);
        // front-most match goes first
        queue_request(REQ_DEL_KEY, '0);
        queue_request(REQ_DUMP, '0);
        queue_request(REQ_DEL_KEY, 32'd12345);
        queue_request(REQ_DEL_KEY, KEY_MIN);
        queue_request(REQ_DEL_FIRST, 32'hdead_beef);
        queue_request(REQ_DEL_LAST, '0);
        // ignored codes
        queue_request(REQ_RSVD_LO, 32'h5555_aaaa);
        queue_request(REQ_RSVD_MID, '0);
        queue_request(REQ_RSVD_HI, '1);
        queue_request(REQ_DUMP, '0);

        // random blocks cycling fill, fill, mixed, drain, drain
        made = 0;
        for (int b = 0; made < RAND_REQS; b++) begin
            case (b % 5)
                0, 1:    mode = 0;
                3, 4:    mode = 1;
                default: mode = 2;
            endcase
            blk_len = $urandom_range(50, 30);
            for (int n = 0; n < blk_len && made < RAND_REQS; n++) begin
                roll = $urandom_range(99, 0);
                if (roll < cuts[mode][0])      code = REQ_INSERT;
                else if (roll < cuts[mode][1]) code = REQ_DEL_KEY;
                else if (roll < cuts[mode][2]) code = REQ_DEL_FIRST;
                else if (roll < cuts[mode][3]) code = REQ_DEL_LAST;
                else if (roll < cuts[mode][4]) code = REQ_DUMP;
                else code = REQ_W'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
                // sender waits for the block to drain at two points
                queue_request(code, pick_key(), made == 0 || made == 300);
                made++;
            end
        end

        // drain and settle
        while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
